// File: rtl/sphd_pkg.sv
// Shared types, constants and helper functions for the solenoid pulse/hold driver.
// Used by sphd_coil_mem, sphd_coil_alu and solenoid_pulse_hold_driver.
`default_nettype none

package sphd_pkg;

    localparam int NUM_COILS      = 56;
    localparam int COIL_IDX_W     = $clog2(NUM_COILS);
    localparam int COIL_CNT_W     = $clog2(NUM_COILS + 1);
    localparam int COIL_NUM_W     = 6;
    localparam int TIME_W         = 8;
    localparam int LEVEL_W        = 8;
    localparam int PAT_IDX_W      = 5;
    localparam int PAT_W          = 16;
    localparam int POS_W          = 4;
    localparam int NUM_GROUPS     = 3;
    localparam int DRIVE_W        = 56;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [COIL_NUM_W-1:0] ALWAYS_WALKED = 6'd32;
    localparam logic [COIL_NUM_W-1:0] STATUS_LIMIT  = 6'd40;
    localparam logic [TIME_W-1:0]     TIME_MAX      = 8'd255;
    localparam logic [TIME_W-1:0]     DEF_PULSE_RST = 8'd20;
    localparam logic [TIME_W-1:0]     DEF_RECYC_RST = 8'd40;
    localparam logic [PAT_IDX_W-1:0]  IDX_FULL      = 5'd16;

    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PULSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIGH    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_PULSE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_RECYCLE = 1'b1;

    localparam logic [PAT_W-1:0] DUTY_TABLE [0:16] = '{
        16'h0000, 16'h0001, 16'h0101, 16'h0821, 16'h1111, 16'h2449,
        16'h4949, 16'h5455, 16'h5555, 16'h38E7, 16'h5D5D, 16'h5DDD,
        16'h7777, 16'hF7BD, 16'hFEFE, 16'hFF7F, 16'hFFFF
    };

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_PULSE        = 3'd1,
        CMD_PULSE_LEVELS = 3'd2,
        CMD_ON           = 3'd3,
        CMD_OFF          = 3'd4,
        CMD_QUERY        = 3'd5,
        CMD_SET_PULSE    = 3'd6,
        CMD_SET_RECYCLE  = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]    pulse_timer;
        logic [TIME_W-1:0]    recycle_timer;
        logic [TIME_W-1:0]    preset_pulse;
        logic [TIME_W-1:0]    preset_recycle;
        logic [PAT_IDX_W-1:0] hold_idx;
        logic [PAT_IDX_W-1:0] cur_idx;
    } coil_row_t;

    localparam coil_row_t COIL_ROW_RESET = '{
        pulse_timer:    '0,
        recycle_timer:  '0,
        preset_pulse:   DEF_PULSE_RST,
        preset_recycle: DEF_RECYC_RST,
        hold_idx:       '0,
        cur_idx:        '0
    };

    typedef struct packed {
        cmd_t               op;
        logic [TIME_W-1:0]  time_value;
        logic [LEVEL_W-1:0] pulse_level;
        logic [LEVEL_W-1:0] hold_level;
        logic [TIME_W-1:0]  def_pulse;
        logic [TIME_W-1:0]  def_recycle;
        logic [POS_W-1:0]   bit_pos;
    } alu_req_t;

    function automatic logic [PAT_IDX_W-1:0] level_to_index(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, lvl} + 9'd1;
        return sum[LEVEL_W:LEVEL_W-4];
    endfunction

    function automatic logic [PAT_W-1:0] pattern_of(input logic [PAT_IDX_W-1:0] idx);
        if (idx > IDX_FULL)
            return DUTY_TABLE[16];
        else
            return DUTY_TABLE[idx];
    endfunction

    // coils below 32 always walk; upper coils walk in groups of eight once enabled
    function automatic logic coil_walked(input logic [COIL_NUM_W-1:0] c,
                                         input logic [NUM_GROUPS-1:0] ge);
        logic [COIL_NUM_W-1:0] off;
        logic                  res;
        off = c - ALWAYS_WALKED;
        if (c < ALWAYS_WALKED)
            res = 1'b1;
        else
        begin
            unique case (off[4:3])
                2'd0:    res = ge[0];
                2'd1:    res = ge[1];
                2'd2:    res = ge[2];
                default: res = 1'b0;
            endcase
        end
        return res;
    endfunction

    function automatic logic [NUM_GROUPS-1:0] group_bit(input logic [COIL_NUM_W-1:0] c);
        logic [COIL_NUM_W-1:0] off;
        logic [NUM_GROUPS-1:0] res;
        off = c - ALWAYS_WALKED;
        res = '0;
        if (c >= ALWAYS_WALKED)
        begin
            unique case (off[4:3])
                2'd0:    res = 3'b001;
                2'd1:    res = 3'b010;
                2'd2:    res = 3'b100;
                default: res = 3'b000;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/solenoid_pulse_hold_driver.sv
// Top level of the solenoid pulse/hold driver: command sequencer, coil walk and result register.
// Depends on sphd_pkg, sphd_coil_mem and sphd_coil_alu.
`default_nettype none

// One command beat in, one result beat out. Per-coil state lives in a memory that is
// read and written once per cycle, and a single update unit processes one coil per
// cycle. A tick reads all 56 coils through that unit with read and write overlapped
// and writes back coils below 32 and those of enabled upper groups; every other
// command works on at most one coil. cmd_stall is high from acceptance until the
// result is loaded into an output register, so the next command is taken while a
// result still waits on res_stall. No clearing pass is needed after reset.
module solenoid_pulse_hold_driver
    import sphd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire logic [2:0]            cmd,
    input  wire logic [COIL_NUM_W-1:0] coil_number,
    input  wire logic [TIME_W-1:0]     time_value,
    input  wire logic [LEVEL_W-1:0]    pulse_level,
    input  wire logic [LEVEL_W-1:0]    hold_level,

    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic [DRIVE_W-1:0]         drive_bits,
    output logic [STATUS_W-1:0]        coil_status
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CMD_RD = 5'b00010,
        ST_CMD_EX = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [COIL_NUM_W-1:0]   coil_num_reg;
    logic [TIME_W-1:0]       tv_reg;
    logic [LEVEL_W-1:0]      plvl_reg;
    logic [LEVEL_W-1:0]      hlvl_reg;
    logic [TIME_W-1:0]       def_pulse_reg;
    logic [TIME_W-1:0]       def_recycle_reg;
    logic [POS_W-1:0]        bit_pos_reg, bit_pos_next;
    logic [NUM_GROUPS-1:0]   grp_en_reg, grp_en_next;
    logic [COIL_CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                    proc_vld_reg, proc_vld_next;
    logic [COIL_IDX_W-1:0]   proc_addr_reg, proc_addr_next;
    logic [DRIVE_W-1:0]      drive_acc_reg, drive_acc_next;
    logic [STATUS_W-1:0]     status_acc_reg, status_acc_next;
    logic                    res_valid_reg, res_valid_next;
    logic [DRIVE_W-1:0]      res_drive_reg, res_drive_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    logic                    accept;
    logic                    num_valid;
    logic [COIL_NUM_W-1:0]   coil_idx_full;
    logic [COIL_IDX_W-1:0]   coil_idx;
    logic                    rd_done;
    logic                    proc_walked;
    logic [DRIVE_W-1:0]      drive_set;

    logic                    mem_rd_en;
    logic [COIL_IDX_W-1:0]   mem_rd_addr;
    logic                    mem_wr_en;
    logic [COIL_IDX_W-1:0]   mem_wr_addr;
    coil_row_t               mem_rd_row;
    coil_row_t               alu_row_new;
    alu_req_t                alu_req;
    logic                    alu_drive;
    logic                    alu_pulsing;

    assign accept        = cmd_valid && !cmd_stall;
    assign cmd_stall     = (state_reg != ST_IDLE);
    assign num_valid     = (coil_num_reg != '0) && (coil_num_reg <= COIL_NUM_W'(NUM_COILS));
    assign coil_idx_full = coil_num_reg - 6'd1;
    assign coil_idx      = coil_idx_full[COIL_IDX_W-1:0];
    assign rd_done       = (rd_cnt_reg == COIL_CNT_W'(NUM_COILS));
    assign proc_walked   = coil_walked(COIL_NUM_W'(proc_addr_reg), grp_en_reg);
    assign drive_set     = {{(DRIVE_W-1){1'b0}}, 1'b1} << proc_addr_reg;

    assign res_valid   = res_valid_reg;
    assign drive_bits  = res_drive_reg;
    assign coil_status = res_status_reg;

    always_comb
    begin
        alu_req.op          = (state_reg == ST_WALK) ? CMD_TICK : cmd_reg;
        alu_req.time_value  = tv_reg;
        alu_req.pulse_level = plvl_reg;
        alu_req.hold_level  = hlvl_reg;
        alu_req.def_pulse   = def_pulse_reg;
        alu_req.def_recycle = def_recycle_reg;
        alu_req.bit_pos     = bit_pos_reg;
    end

    sphd_coil_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_row  (mem_rd_row),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_row  (alu_row_new)
    );

    sphd_coil_alu u_alu (
        .req     (alu_req),
        .row     (mem_rd_row),
        .row_new (alu_row_new),
        .drive   (alu_drive),
        .pulsing (alu_pulsing)
    );

    always_comb
    begin
        state_next      = state_reg;
        bit_pos_next    = bit_pos_reg;
        grp_en_next     = grp_en_reg;
        rd_cnt_next     = rd_cnt_reg;
        proc_vld_next   = 1'b0;
        proc_addr_next  = proc_addr_reg;
        drive_acc_next  = drive_acc_reg;
        status_acc_next = status_acc_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_drive_next  = res_drive_reg;
        res_status_next = res_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = coil_idx;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = coil_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    drive_acc_next  = '0;
                    status_acc_next = STATUS_NONE;
                    rd_cnt_next     = '0;
                    if (cmd_t'(cmd) == CMD_TICK)
                    begin
                        bit_pos_next = bit_pos_reg + 4'd1;
                        state_next   = ST_WALK;
                    end
                    else
                        state_next = ST_CMD_RD;
                end
            end
            ST_CMD_RD:
            begin
                mem_rd_en  = num_valid;
                state_next = ST_CMD_EX;
            end
            ST_CMD_EX:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    if (coil_num_reg > STATUS_LIMIT)
                        status_acc_next = STATUS_HIGH;
                    else if (num_valid && alu_pulsing)
                        status_acc_next = STATUS_PULSING;
                end
                else if (num_valid)
                begin
                    mem_wr_en = 1'b1;
                    if ((cmd_reg == CMD_SET_PULSE) || (cmd_reg == CMD_SET_RECYCLE))
                        grp_en_next = grp_en_reg | group_bit(coil_idx_full);
                end
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                // read of coil n overlaps the update and write-back of coil n-1
                if (!rd_done)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = rd_cnt_reg[COIL_IDX_W-1:0];
                    rd_cnt_next    = rd_cnt_reg + COIL_CNT_W'(1);
                    proc_vld_next  = 1'b1;
                    proc_addr_next = rd_cnt_reg[COIL_IDX_W-1:0];
                end
                if (proc_vld_reg && proc_walked)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = proc_addr_reg;
                    if (alu_drive)
                        drive_acc_next = drive_acc_reg | drive_set;
                end
                if (rd_done && !proc_vld_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_drive_next  = drive_acc_reg;
                    res_status_next = status_acc_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            def_pulse_reg   <= DEF_PULSE_RST;
            def_recycle_reg <= DEF_RECYC_RST;
            bit_pos_reg     <= '0;
            grp_en_reg      <= '0;
            rd_cnt_reg      <= '0;
            proc_vld_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_pos_reg   <= bit_pos_next;
            grp_en_reg    <= grp_en_next;
            rd_cnt_reg    <= rd_cnt_next;
            proc_vld_reg  <= proc_vld_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEF_PULSE:   def_pulse_reg   <= cfg_data;
                    CFG_DEF_RECYCLE: def_recycle_reg <= cfg_data;
                    default:         def_pulse_reg   <= def_pulse_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(cmd);
            coil_num_reg <= coil_number;
            tv_reg       <= time_value;
            plvl_reg     <= pulse_level;
            hlvl_reg     <= hold_level;
        end
        proc_addr_reg  <= proc_addr_next;
        drive_acc_reg  <= drive_acc_next;
        status_acc_reg <= status_acc_next;
        res_drive_reg  <= res_drive_next;
        res_status_reg <= res_status_next;
    end

`ifndef SYNTH
    a_rw_addr_differ: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("coil memory read and write hit the same entry");

    a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= COIL_CNT_W'(NUM_COILS))
        else $error("walk counter past last coil");

    a_wr_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> ((state_reg == ST_CMD_EX) || proc_vld_reg))
        else $error("coil write outside execute or walk");

    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat not from done state");

    a_tick_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_t'(cmd) == CMD_TICK)) |=> (bit_pos_reg == $past(bit_pos_reg) + 4'd1))
        else $error("pattern position did not advance on tick");

    a_status_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_status_reg != STATUS_NONE)) |-> (res_drive_reg == '0))
        else $error("status and drive bits both set");
`endif

endmodule

`default_nettype wire

// File: rtl/sphd_coil_mem.sv
// Per-coil state memory: one write and one registered read port per cycle.
// Entries never written read as the reset row. Depends on sphd_pkg.
`default_nettype none

module sphd_coil_mem
    import sphd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [COIL_IDX_W-1:0] rd_addr,
    output coil_row_t                  rd_row,
    input  wire logic                  wr_en,
    input  wire logic [COIL_IDX_W-1:0] wr_addr,
    input  wire coil_row_t             wr_row
);

    coil_row_t             mem_reg [NUM_COILS];
    coil_row_t             q_reg;
    logic                  q_vld_reg;
    logic [NUM_COILS-1:0]  vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_row;
        if (rd_en)
            q_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                q_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_row = q_vld_reg ? q_reg : COIL_ROW_RESET;

endmodule

`default_nettype wire

// File: rtl/sphd_coil_alu.sv
// Shared coil update unit: applies a tick or a single-coil command to one state row.
// Depends on sphd_pkg.
`default_nettype none

module sphd_coil_alu
    import sphd_pkg::*;
(
    input  wire alu_req_t  req,
    input  wire coil_row_t row,
    output coil_row_t      row_new,
    output logic           drive,
    output logic           pulsing
);

    logic [TIME_W-1:0] rec_dec;
    logic [TIME_W-1:0] pt_dec;
    logic [PAT_W-1:0]  pat;

    assign pulsing = (row.pulse_timer != '0) && (row.recycle_timer == '0);
    assign rec_dec = (row.recycle_timer != '0) ? row.recycle_timer - 8'd1 : '0;
    assign pat     = pattern_of(row.cur_idx);
    assign pt_dec  = ((row.hold_idx != IDX_FULL) && (row.preset_recycle != '0))
                     ? row.pulse_timer - 8'd1 : row.pulse_timer;

    always_comb
    begin
        row_new = row;
        drive   = 1'b0;
        unique case (req.op)
            CMD_TICK:
            begin
                row_new.recycle_timer = rec_dec;
                if ((row.pulse_timer != '0) && (rec_dec == '0))
                begin
                    row_new.pulse_timer = pt_dec;
                    drive = pat[req.bit_pos];
                    if (pt_dec == '0)
                    begin
                        if (row.hold_idx == '0)
                            row_new.recycle_timer = row.preset_recycle;
                        else
                        begin
                            // pulse done: fall into endless hold
                            row_new.cur_idx        = row.hold_idx;
                            row_new.preset_pulse   = TIME_MAX;
                            row_new.preset_recycle = '0;
                            row_new.pulse_timer    = TIME_MAX;
                        end
                    end
                end
            end
            CMD_PULSE:
            begin
                if (row.pulse_timer == '0)
                    row_new.pulse_timer = row.preset_pulse;
                row_new.hold_idx = '0;
                row_new.cur_idx  = IDX_FULL;
            end
            CMD_PULSE_LEVELS:
            begin
                if (row.pulse_timer == '0)
                begin
                    row_new.pulse_timer = req.time_value;
                    row_new.hold_idx    = level_to_index(req.hold_level);
                    row_new.cur_idx     = level_to_index(req.pulse_level);
                end
            end
            CMD_ON:
            begin
                if (row.pulse_timer == '0)
                begin
                    row_new.pulse_timer    = TIME_MAX;
                    row_new.preset_pulse   = TIME_MAX;
                    row_new.preset_recycle = '0;
                    row_new.hold_idx       = IDX_FULL;
                    row_new.cur_idx        = IDX_FULL;
                end
            end
            CMD_OFF:
            begin
                row_new.pulse_timer    = '0;
                row_new.preset_pulse   = req.def_pulse;
                row_new.preset_recycle = req.def_recycle;
                row_new.hold_idx       = '0;
                row_new.cur_idx        = IDX_FULL;
            end
            CMD_QUERY:
            begin
                row_new = row;
            end
            CMD_SET_PULSE:
            begin
                row_new.preset_pulse = req.time_value;
            end
            CMD_SET_RECYCLE:
            begin
                row_new.preset_recycle = req.time_value;
            end
            default:
            begin
                row_new = row;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/solenoid_pulse_hold_driver_tb.sv
// Self-checking testbench for solenoid_pulse_hold_driver: directed, register and random traffic.
// Keeps its own coil state to predict drive_bits and coil_status; depends on sphd_pkg.
`default_nettype none

module solenoid_pulse_hold_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sphd_pkg::*;

    localparam int SETTLE_CYCLES = 70;

    localparam logic [PAT_W-1:0] DUTY_PATTERNS [0:16] = '{
        16'h0000, 16'h0001, 16'h0101, 16'h0821, 16'h1111, 16'h2449,
        16'h4949, 16'h5455, 16'h5555, 16'h38E7, 16'h5D5D, 16'h5DDD,
        16'h7777, 16'hF7BD, 16'hFEFE, 16'hFF7F, 16'hFFFF
    };

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive;
        logic [STATUS_W-1:0] status;
    } coil_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEF_PULSE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd_in = CMD_TICK;
    logic [COIL_NUM_W-1:0] coil_number = '0;
    logic [TIME_W-1:0]     time_value = '0;
    logic [LEVEL_W-1:0]    pulse_level = '0;
    logic [LEVEL_W-1:0]    hold_level = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [DRIVE_W-1:0]    drive_bits;
    logic [STATUS_W-1:0]   coil_status;

    // predicted coil state
    logic [TIME_W-1:0]    pulse_left     [NUM_COILS];
    logic [TIME_W-1:0]    recycle_left   [NUM_COILS];
    logic [TIME_W-1:0]    pulse_preset   [NUM_COILS];
    logic [TIME_W-1:0]    recycle_preset [NUM_COILS];
    logic [PAT_IDX_W-1:0] hold_sel       [NUM_COILS];
    logic [PAT_IDX_W-1:0] drive_sel      [NUM_COILS];
    logic [POS_W-1:0]     pattern_pos;
    logic [NUM_GROUPS-1:0] upper_groups;
    logic [TIME_W-1:0]    dflt_pulse;
    logic [TIME_W-1:0]    dflt_recycle;

    coil_result_t pending_results [$];
    int  mismatch_count = 0;
    int  beat_count = 0;
    int  tick_count = 0;
    int  query_count = 0;
    int  setting_count = 1;
    bit  quiet = 1'b0;

    solenoid_pulse_hold_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd_in),
        .coil_number (coil_number),
        .time_value  (time_value),
        .pulse_level (pulse_level),
        .hold_level  (hold_level),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .drive_bits  (drive_bits),
        .coil_status (coil_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [PAT_IDX_W-1:0] duty_index(input logic [LEVEL_W-1:0] lvl);
        return PAT_IDX_W'((int'(lvl) + 1) / 16);
    endfunction

    task automatic reset_coil_state();
        for (int k = 0; k < NUM_COILS; k++)
        begin
            pulse_left[k]     = '0;
            recycle_left[k]   = '0;
            pulse_preset[k]   = 8'd20;
            recycle_preset[k] = 8'd40;
            hold_sel[k]       = '0;
            drive_sel[k]      = '0;
        end
        pattern_pos  = '0;
        upper_groups = '0;
        dflt_pulse   = 8'd20;
        dflt_recycle = 8'd40;
    endtask

    function automatic coil_result_t apply_command(input cmd_t op,
                                                   input logic [COIL_NUM_W-1:0] num,
                                                   input logic [TIME_W-1:0] tv,
                                                   input logic [LEVEL_W-1:0] pl,
                                                   input logic [LEVEL_W-1:0] hl);
        coil_result_t r;
        int           c;
        bit           ok;
        logic         walked;
        logic [PAT_W-1:0] pat;
        r  = '0;
        c  = int'(num) - 1;
        ok = (num >= 1) && (num <= NUM_COILS);
        if (op == CMD_TICK)
        begin
            pattern_pos = pattern_pos + 4'd1;
            for (int k = 0; k < NUM_COILS; k++)
            begin
                walked = (k < 32) ? 1'b1 : upper_groups[(k - 32) / 8];
                if (walked)
                begin
                    if (recycle_left[k] != 0)
                        recycle_left[k] = recycle_left[k] - 8'd1;
                    if (pulse_left[k] != 0 && recycle_left[k] == 0)
                    begin
                        if (hold_sel[k] != 5'd16 && recycle_preset[k] != 0)
                            pulse_left[k] = pulse_left[k] - 8'd1;
                        pat = DUTY_PATTERNS[drive_sel[k] > 5'd16 ? 5'd16 : drive_sel[k]];
                        r.drive[k] = pat[pattern_pos];
                        if (pulse_left[k] == 0)
                        begin
                            if (hold_sel[k] == 0)
                                recycle_left[k] = recycle_preset[k];
                            else
                            begin
                                drive_sel[k]      = hold_sel[k];
                                pulse_preset[k]   = 8'd255;
                                recycle_preset[k] = 8'd0;
                                pulse_left[k]     = 8'd255;
                            end
                        end
                    end
                end
            end
        end
        else if (op == CMD_QUERY)
        begin
            if (num > 40)
                r.status = STATUS_HIGH;
            else if (ok && pulse_left[c] != 0 && recycle_left[c] == 0)
                r.status = STATUS_PULSING;
        end
        else if (ok)
        begin
            case (op)
                CMD_PULSE:
                begin
                    if (pulse_left[c] == 0)
                        pulse_left[c] = pulse_preset[c];
                    hold_sel[c]  = 5'd0;
                    drive_sel[c] = 5'd16;
                end
                CMD_PULSE_LEVELS:
                begin
                    if (pulse_left[c] == 0)
                    begin
                        pulse_left[c] = tv;
                        hold_sel[c]   = duty_index(hl);
                        drive_sel[c]  = duty_index(pl);
                    end
                end
                CMD_ON:
                begin
                    if (pulse_left[c] == 0)
                    begin
                        pulse_left[c]     = 8'd255;
                        pulse_preset[c]   = 8'd255;
                        recycle_preset[c] = 8'd0;
                        hold_sel[c]       = 5'd16;
                        drive_sel[c]      = 5'd16;
                    end
                end
                CMD_OFF:
                begin
                    pulse_left[c]     = 8'd0;
                    pulse_preset[c]   = dflt_pulse;
                    recycle_preset[c] = dflt_recycle;
                    hold_sel[c]       = 5'd0;
                    drive_sel[c]      = 5'd16;
                end
                default:
                begin
                    if (c >= 32)
                        upper_groups[(c - 32) / 8] = 1'b1;
                    if (op == CMD_SET_PULSE)
                        pulse_preset[c] = tv;
                    else
                        recycle_preset[c] = tv;
                end
            endcase
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(negedge clk)
        res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 20);

    always @(posedge clk)
    begin
        coil_result_t exp_beat;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                log_mismatch("unexpected result beat", '0, 64'(drive_bits));
            else
            begin
                exp_beat = pending_results.pop_front();
                if (drive_bits !== exp_beat.drive)
                    log_mismatch("drive_bits", 64'(exp_beat.drive), 64'(drive_bits));
                if (coil_status !== exp_beat.status)
                    log_mismatch("coil_status", 64'(exp_beat.status), 64'(coil_status));
            end
        end
    end

    task automatic send_beat(input cmd_t op, input logic [COIL_NUM_W-1:0] num,
                             input logic [TIME_W-1:0] tv, input logic [LEVEL_W-1:0] pl,
                             input logic [LEVEL_W-1:0] hl);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 8);
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_in      <= op;
        coil_number <= num;
        time_value  <= tv;
        pulse_level <= pl;
        hold_level  <= hl;
        cmd_valid   <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_results.push_back(apply_command(op, num, tv, pl, hl));
        beat_count++;
        if (op == CMD_TICK)
            tick_count++;
        if (op == CMD_QUERY)
            query_count++;
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_default(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEF_PULSE)
            dflt_pulse = val;
        else
            dflt_recycle = val;
        setting_count++;
    endtask

    task automatic test_directed_commands();
        send_beat(CMD_QUERY, 6'd0, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_QUERY, 6'd40, 8'd255, 8'd255, 8'd255);
        send_beat(CMD_QUERY, 6'd41, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_QUERY, 6'd63, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd1, 8'd0, 8'd0, 8'd0);
        send_tick();
        send_beat(CMD_QUERY, 6'd1, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd1, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE_LEVELS, 6'd2, 8'd3, 8'd255, 8'd0);
        send_beat(CMD_PULSE_LEVELS, 6'd3, 8'd255, 8'd0, 8'd255);
        send_beat(CMD_ON, 6'd4, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE_LEVELS, 6'd4, 8'd5, 8'd100, 8'd100);
        send_beat(CMD_SET_PULSE, 6'd0, 8'd9, 8'd0, 8'd0);
        send_beat(CMD_SET_RECYCLE, 6'd57, 8'd9, 8'd0, 8'd0);
        send_beat(CMD_SET_PULSE, 6'd33, 8'd2, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd33, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_SET_RECYCLE, 6'd48, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE_LEVELS, 6'd48, 8'd2, 8'd14, 8'd15);
        send_beat(CMD_SET_PULSE, 6'd56, 8'd255, 8'd0, 8'd0);
        repeat (4) send_tick();
        send_beat(CMD_OFF, 6'd4, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_OFF, 6'd0, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_QUERY, 6'd4, 8'd0, 8'd0, 8'd0);
        send_tick();
    endtask

    task automatic test_default_registers();
        write_default(CFG_DEF_PULSE, 8'd0);
        write_default(CFG_DEF_RECYCLE, 8'd255);
        send_beat(CMD_OFF, 6'd7, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd7, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_SET_PULSE, 6'd7, 8'd2, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd7, 8'd0, 8'd0, 8'd0);
        repeat (4) send_tick();
        send_beat(CMD_QUERY, 6'd7, 8'd0, 8'd0, 8'd0);
        write_default(CFG_DEF_PULSE, 8'd255);
        write_default(CFG_DEF_RECYCLE, 8'd0);
        send_beat(CMD_OFF, 6'd8, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_PULSE, 6'd8, 8'd0, 8'd0, 8'd0);
        repeat (3) send_tick();
        send_beat(CMD_QUERY, 6'd8, 8'd0, 8'd0, 8'd0);
        send_beat(CMD_OFF, 6'd8, 8'd0, 8'd0, 8'd0);
        send_tick();
    endtask

    function automatic logic [COIL_NUM_W-1:0] pick_coil();
        if ($urandom_range(0, 9) < 7)
            return 6'($urandom_range(1, 32));
        return 6'($urandom_range(33, 56));
    endfunction

    task automatic test_random_traffic(input int n);
        int                    first;
        int                    done;
        logic [COIL_NUM_W-1:0] coil;
        first = beat_count;
        done  = 0;
        while (done < n)
        begin
            quiet = (done > n / 3) && (done < n / 2);
            coil  = pick_coil();
            if ($urandom_range(0, 99) < 70)
            begin
                if ($urandom_range(0, 1))
                    send_beat(CMD_SET_PULSE, coil, 8'($urandom_range(0, 6)),
                              8'($urandom), 8'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send_beat(CMD_SET_RECYCLE, coil,
                              $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 5)) : 8'($urandom),
                              8'($urandom), 8'($urandom));
                case ($urandom_range(0, 3))
                    0: send_beat(CMD_PULSE, coil, 8'($urandom), 8'($urandom), 8'($urandom));
                    1: send_beat(CMD_PULSE_LEVELS, coil,
                                 $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 8)) : 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    2: send_beat(CMD_ON, coil, 8'($urandom), 8'($urandom), 8'($urandom));
                    default: send_beat(CMD_OFF, coil, 8'($urandom), 8'($urandom), 8'($urandom));
                endcase
                repeat ($urandom_range(1, 10))
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(CMD_QUERY, coil, 8'($urandom), 8'($urandom), 8'($urandom));
                    else
                        send_tick();
                end
                if ($urandom_range(0, 5) == 0)
                    send_beat(CMD_OFF, coil, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else
                send_beat(cmd_t'($urandom_range(0, 7)), 6'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            done = beat_count - first;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        reset_coil_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_commands();
        test_default_registers();
        test_random_traffic(450);
        write_default(CFG_DEF_PULSE, 8'($urandom));
        write_default(CFG_DEF_RECYCLE, 8'($urandom_range(1, 8)));
        test_random_traffic(450);
        write_default(CFG_DEF_PULSE, 8'($urandom_range(1, 6)));
        write_default(CFG_DEF_RECYCLE, 8'($urandom));
        test_random_traffic(400);

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d command beats (%0d ticks, %0d queries) over %0d register settings.",
                 beat_count, tick_count, query_count, setting_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches in total", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
